[hdl/clnp_pkg.sv]
// Shared types, constants and the half-shell offset table for the cell-list pair unit.
// No dependencies.
package clnp_pkg;

  localparam int MaxParticles = 1024;
  localparam int MaxCells     = 4096;
  localparam int PW           = $clog2(MaxParticles);   // particle index bits
  localparam int CW           = $clog2(MaxCells);       // cell index bits

  // list link: top bit set marks an empty link
  localparam logic [PW:0] LINK_NONE = {(PW+1){1'b1}};

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BIN   = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;

  localparam logic [3:0] REG_PARTICLE_COUNT = 4'd0;
  localparam logic [3:0] REG_CELLS_X        = 4'd1;
  localparam logic [3:0] REG_CELLS_Y        = 4'd2;
  localparam logic [3:0] REG_CELLS_Z        = 4'd3;
  localparam logic [3:0] REG_INV_WIDTH_X    = 4'd4;
  localparam logic [3:0] REG_INV_WIDTH_Y    = 4'd5;
  localparam logic [3:0] REG_INV_WIDTH_Z    = 4'd6;
  localparam logic [3:0] REG_TWO_DIM        = 4'd7;

  localparam logic [1:0] OFF_ZERO  = 2'd0;
  localparam logic [1:0] OFF_PLUS  = 2'd1;
  localparam logic [1:0] OFF_MINUS = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  particle_index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic [9:0] pair_first;
    logic [9:0] pair_second;
    logic       status;
  } out_word_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_BIN_INIT,
    CMD_CLR,
    CMD_POS_RD,
    CMD_MUL_X,
    CMD_MUL_Y,
    CMD_MUL_Z,
    CMD_CELL1,
    CMD_CELL2,
    CMD_HEAD_RD_BIN,
    CMD_BIN_WR,
    CMD_WALK_INIT,
    CMD_EMIT_EXH,
    CMD_FINISH,
    CMD_HEAD_RD_CELL,
    CMD_FIRST_FROM_HEAD,
    CMD_SEC_FROM_LINK,
    CMD_EMIT_PAIR,
    CMD_NB1,
    CMD_NB2,
    CMD_NB_RD,
    CMD_SEC_FROM_HEAD,
    CMD_LINK_RD_FIRST,
    CMD_FIRST_FROM_LINK
  } cmd_t;

  typedef struct packed {
    logic done;
    logic first_none;
    logic second_none;
    logic cell_end;
    logic nbr_end;
    logic head_none;
    logic link_none;
    logic clr_last;
    logic bin_end;
  } stat_t;

  // {dx, dy, dz} of half-shell neighbor k
  function automatic logic [5:0] nbr_off(input logic [3:0] k);
    logic [5:0] r;
    case (k)
      4'd0:    r = {OFF_PLUS,  OFF_ZERO, OFF_ZERO};
      4'd1:    r = {OFF_PLUS,  OFF_PLUS, OFF_ZERO};
      4'd2:    r = {OFF_ZERO,  OFF_PLUS, OFF_ZERO};
      4'd3:    r = {OFF_MINUS, OFF_PLUS, OFF_ZERO};
      4'd4:    r = {OFF_PLUS,  OFF_ZERO, OFF_MINUS};
      4'd5:    r = {OFF_PLUS,  OFF_PLUS, OFF_MINUS};
      4'd6:    r = {OFF_ZERO,  OFF_PLUS, OFF_MINUS};
      4'd7:    r = {OFF_MINUS, OFF_PLUS, OFF_MINUS};
      4'd8:    r = {OFF_PLUS,  OFF_ZERO, OFF_PLUS};
      4'd9:    r = {OFF_PLUS,  OFF_PLUS, OFF_PLUS};
      4'd10:   r = {OFF_ZERO,  OFF_PLUS, OFF_PLUS};
      4'd11:   r = {OFF_MINUS, OFF_PLUS, OFF_PLUS};
      4'd12:   r = {OFF_ZERO,  OFF_ZERO, OFF_PLUS};
      default: r = {OFF_ZERO,  OFF_ZERO, OFF_ZERO};
    endcase
    return r;
  endfunction

endpackage

[hdl/clnp_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module clnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/clnp_dp.sv]
// Datapath: config registers, position/head/link memories, binning and walk registers.
// Depends on clnp_pkg and clnp_ram.
module clnp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  clnp_pkg::cmd_t     cmd,
  input  clnp_pkg::in_word_t in_word,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output clnp_pkg::stat_t    stat,
  output clnp_pkg::out_word_t out_word
);

  localparam int PW = clnp_pkg::PW;
  localparam int CW = clnp_pkg::CW;

  // config
  logic [10:0] pc_r;
  logic [4:0]  cx_r, cy_r, cz_r;
  logic [23:0] iwx_r, iwy_r, iwz_r;
  logic        td_r;
  // latched at bin
  logic [10:0] n_r;
  logic [4:0]  lcx_r, lcy_r, lcz_r;
  logic [3:0]  nn_r;
  logic        l2d_r;
  logic [8:0]  xy_r;
  logic [12:0] ncell_r;
  // binning
  logic [CW-1:0] clr_r;
  logic [10:0]   pidx_r;
  logic [3:0]    bx_r, by_r, bz_r;
  logic [7:0]    bt_r;
  logic [CW-1:0] bcell_r;
  // walk
  logic [12:0] wcell_r;
  logic [3:0]  wx_r, wy_r, wz_r;
  logic [PW:0] first_r, second_r;
  logic [3:0]  nbr_r;
  logic        done_r;
  logic [7:0]  nt_r;
  logic [3:0]  nz_r;
  logic [CW-1:0] nbcell_r;
  clnp_pkg::out_word_t out_r;

  // memories
  logic          p_we, p_re;
  logic [95:0]   p_rdata;
  logic          h_we, h_re;
  logic [CW-1:0] h_addr;
  logic [PW:0]   h_wdata, h_rdata;
  logic          l_we, l_re;
  logic [PW-1:0] l_addr;
  logic [PW:0]   l_rdata;

  assign p_we = (cmd == clnp_pkg::CMD_LOAD);
  assign p_re = (cmd == clnp_pkg::CMD_POS_RD);

  clnp_ram #(.WIDTH(96), .DEPTH(clnp_pkg::MaxParticles)) u_pos (
    .clk(clk), .we(p_we), .re(p_re),
    .addr(p_we ? in_word.particle_index : pidx_r[PW-1:0]),
    .wdata({in_word.pos_x, in_word.pos_y, in_word.pos_z}),
    .rdata(p_rdata)
  );

  always_comb begin
    h_we    = 1'b0;
    h_re    = 1'b0;
    h_addr  = wcell_r[CW-1:0];
    h_wdata = clnp_pkg::LINK_NONE;
    case (cmd)
      clnp_pkg::CMD_CLR: begin
        h_we   = 1'b1;
        h_addr = clr_r;
      end
      clnp_pkg::CMD_HEAD_RD_BIN: begin
        h_re   = 1'b1;
        h_addr = bcell_r;
      end
      clnp_pkg::CMD_BIN_WR: begin
        h_we    = 1'b1;
        h_addr  = bcell_r;
        h_wdata = {1'b0, pidx_r[PW-1:0]};
      end
      clnp_pkg::CMD_HEAD_RD_CELL: h_re = 1'b1;
      clnp_pkg::CMD_NB_RD: begin
        h_re   = 1'b1;
        h_addr = nbcell_r;
      end
      default: ;
    endcase
  end

  clnp_ram #(.WIDTH(PW+1), .DEPTH(clnp_pkg::MaxCells)) u_head (
    .clk(clk), .we(h_we), .re(h_re), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
  );

  always_comb begin
    l_we   = 1'b0;
    l_re   = 1'b0;
    l_addr = first_r[PW-1:0];
    case (cmd)
      clnp_pkg::CMD_BIN_WR: begin
        l_we   = 1'b1;
        l_addr = pidx_r[PW-1:0];
      end
      clnp_pkg::CMD_EMIT_PAIR: begin
        l_re   = 1'b1;
        l_addr = second_r[PW-1:0];
      end
      clnp_pkg::CMD_FIRST_FROM_HEAD: begin
        l_re   = ~h_rdata[PW];
        l_addr = h_rdata[PW-1:0];
      end
      clnp_pkg::CMD_LINK_RD_FIRST: l_re = 1'b1;
      clnp_pkg::CMD_FIRST_FROM_LINK: begin
        l_re   = ~l_rdata[PW];
        l_addr = l_rdata[PW-1:0];
      end
      default: ;
    endcase
  end

  clnp_ram #(.WIDTH(PW+1), .DEPTH(clnp_pkg::MaxParticles)) u_link (
    .clk(clk), .we(l_we), .re(l_re), .addr(l_addr), .wdata(h_rdata), .rdata(l_rdata)
  );

  // shared cell-coordinate multiplier: floor(pos * inv) clamped to count - 1
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [4:0]  mul_n;
  logic [55:0] mul_p;
  logic [3:0]  mul_c;

  always_comb begin
    case (cmd)
      clnp_pkg::CMD_MUL_X: begin
        mul_a = p_rdata[95:64]; mul_b = iwx_r; mul_n = lcx_r;
      end
      clnp_pkg::CMD_MUL_Y: begin
        mul_a = p_rdata[63:32]; mul_b = iwy_r; mul_n = lcy_r;
      end
      default: begin
        mul_a = p_rdata[31:0];  mul_b = iwz_r; mul_n = lcz_r;
      end
    endcase
    mul_p = 56'(mul_a) * 56'(mul_b);
    mul_c = (mul_p[55:32] > 24'(mul_n - 5'd1)) ? 4'(mul_n - 5'd1) : mul_p[35:32];
  end

  // periodic wrap of one coordinate by -1, 0 or +1
  function automatic logic [3:0] wrap_c(input logic [3:0] c, input logic [1:0] off,
                                        input logic [4:0] n);
    logic [3:0] top;
    logic [3:0] r;
    top = 4'(n - 5'd1);
    case (off)
      clnp_pkg::OFF_PLUS:  r = (c == top) ? 4'd0 : c + 4'd1;
      clnp_pkg::OFF_MINUS: r = (c == 4'd0) ? top : c - 4'd1;
      default:             r = c;
    endcase
    return r;
  endfunction

  logic [5:0] off;
  logic [3:0] nx, ny, nz;
  logic [8:0] nt_full;
  logic [12:0] nc_full, bc_full;
  logic [8:0]  bt_full;

  assign off     = clnp_pkg::nbr_off(nbr_r);
  assign nx      = wrap_c(wx_r, off[5:4], lcx_r);
  assign ny      = wrap_c(wy_r, off[3:2], lcy_r);
  assign nz      = wrap_c(wz_r, off[1:0], lcz_r);
  assign nt_full = 9'(nx) * 9'(lcy_r) + 9'(ny);
  assign nc_full = 13'(nt_r) * 13'(lcz_r) + 13'(nz_r);
  assign bt_full = 9'(bx_r) * 9'(lcy_r) + 9'(by_r);
  assign bc_full = 13'(bt_r) * 13'(lcz_r) + 13'(bz_r);

  // next walk cell in z, y, x nested order
  logic [12:0] adv_cell;
  logic [3:0]  adv_x, adv_y, adv_z;
  always_comb begin
    adv_cell = wcell_r + 13'd1;
    adv_x = wx_r;
    adv_y = wy_r;
    adv_z = wz_r + 4'd1;
    if (wz_r == 4'(lcz_r - 5'd1)) begin
      adv_z = 4'd0;
      adv_y = wy_r + 4'd1;
      if (wy_r == 4'(lcy_r - 5'd1)) begin
        adv_y = 4'd0;
        adv_x = wx_r + 4'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= 11'd1;
      cx_r  <= 5'd1;
      cy_r  <= 5'd1;
      cz_r  <= 5'd1;
      iwx_r <= 24'd65536;
      iwy_r <= 24'd65536;
      iwz_r <= 24'd65536;
      td_r  <= 1'b0;
      n_r   <= 11'd1;
      lcx_r <= 5'd1;
      lcy_r <= 5'd1;
      lcz_r <= 5'd1;
      nn_r  <= 4'd13;
      l2d_r <= 1'b0;
      xy_r  <= 9'd1;
      ncell_r <= 13'd1;
      clr_r <= '0;
      pidx_r <= '0;
      wcell_r <= '0;
      wx_r <= '0;
      wy_r <= '0;
      wz_r <= '0;
      first_r <= clnp_pkg::LINK_NONE;
      second_r <= clnp_pkg::LINK_NONE;
      nbr_r <= '0;
      done_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          clnp_pkg::REG_PARTICLE_COUNT: pc_r  <= cfg_data[10:0];
          clnp_pkg::REG_CELLS_X:        cx_r  <= cfg_data[4:0];
          clnp_pkg::REG_CELLS_Y:        cy_r  <= cfg_data[4:0];
          clnp_pkg::REG_CELLS_Z:        cz_r  <= cfg_data[4:0];
          clnp_pkg::REG_INV_WIDTH_X:    iwx_r <= cfg_data;
          clnp_pkg::REG_INV_WIDTH_Y:    iwy_r <= cfg_data;
          clnp_pkg::REG_INV_WIDTH_Z:    iwz_r <= cfg_data;
          clnp_pkg::REG_TWO_DIM:        td_r  <= cfg_data[0];
          default: ;
        endcase
      end
      xy_r    <= 9'(lcx_r) * 9'(lcy_r);
      ncell_r <= 13'(xy_r) * 13'(lcz_r);
      case (cmd)
        clnp_pkg::CMD_BIN_INIT: begin
          n_r   <= (pc_r > 11'(clnp_pkg::MaxParticles)) ? 11'(clnp_pkg::MaxParticles) : pc_r;
          lcx_r <= (cx_r == 5'd0) ? 5'd1 : (cx_r > 5'd16) ? 5'd16 : cx_r;
          lcy_r <= (cy_r == 5'd0) ? 5'd1 : (cy_r > 5'd16) ? 5'd16 : cy_r;
          lcz_r <= td_r ? 5'd1 : (cz_r == 5'd0) ? 5'd1 : (cz_r > 5'd16) ? 5'd16 : cz_r;
          nn_r  <= td_r ? 4'd4 : 4'd13;
          l2d_r <= td_r;
          clr_r <= '0;
          pidx_r <= '0;
        end
        clnp_pkg::CMD_CLR:    clr_r  <= clr_r + 1'b1;
        clnp_pkg::CMD_BIN_WR: pidx_r <= pidx_r + 11'd1;
        clnp_pkg::CMD_WALK_INIT: begin
          wcell_r <= '0;
          wx_r <= '0;
          wy_r <= '0;
          wz_r <= '0;
          first_r <= clnp_pkg::LINK_NONE;
          second_r <= clnp_pkg::LINK_NONE;
          nbr_r <= '0;
          done_r <= 1'b0;
        end
        clnp_pkg::CMD_FINISH: done_r <= 1'b1;
        clnp_pkg::CMD_FIRST_FROM_HEAD, clnp_pkg::CMD_FIRST_FROM_LINK: begin
          first_r <= (cmd == clnp_pkg::CMD_FIRST_FROM_HEAD) ? h_rdata : l_rdata;
          nbr_r <= '0;
          if ((cmd == clnp_pkg::CMD_FIRST_FROM_HEAD) ? h_rdata[PW] : l_rdata[PW]) begin
            wcell_r <= adv_cell;
            wx_r <= adv_x;
            wy_r <= adv_y;
            wz_r <= adv_z;
          end
        end
        clnp_pkg::CMD_SEC_FROM_LINK: second_r <= l_rdata;
        clnp_pkg::CMD_SEC_FROM_HEAD: begin
          second_r <= h_rdata;
          nbr_r <= nbr_r + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      clnp_pkg::CMD_MUL_X: bx_r <= mul_c;
      clnp_pkg::CMD_MUL_Y: by_r <= mul_c;
      clnp_pkg::CMD_MUL_Z: bz_r <= l2d_r ? 4'd0 : mul_c;
      clnp_pkg::CMD_CELL1: bt_r <= bt_full[7:0];
      clnp_pkg::CMD_CELL2: bcell_r <= bc_full[CW-1:0];
      clnp_pkg::CMD_NB1: begin
        nt_r <= nt_full[7:0];
        nz_r <= nz;
      end
      clnp_pkg::CMD_NB2: nbcell_r <= nc_full[CW-1:0];
      clnp_pkg::CMD_EMIT_PAIR: begin
        out_r.pair_first  <= first_r[PW-1:0];
        out_r.pair_second <= second_r[PW-1:0];
        out_r.status      <= 1'b0;
      end
      clnp_pkg::CMD_EMIT_EXH, clnp_pkg::CMD_FINISH: begin
        out_r.pair_first  <= '0;
        out_r.pair_second <= '0;
        out_r.status      <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_word = out_r;

  assign stat.done        = done_r;
  assign stat.first_none  = first_r[PW];
  assign stat.second_none = second_r[PW];
  assign stat.cell_end    = (wcell_r >= ncell_r);
  assign stat.nbr_end     = (nbr_r >= nn_r);
  assign stat.head_none   = h_rdata[PW];
  assign stat.link_none   = l_rdata[PW];
  assign stat.clr_last    = (clr_r == {CW{1'b1}});
  assign stat.bin_end     = (pidx_r >= n_r);

endmodule

[hdl/clnp_ctrl.sv]
// Controller: sequences loading, binning and the pair walk; owns the result valid.
// Depends on clnp_pkg.
module clnp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_mode,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  clnp_pkg::stat_t stat,
  output clnp_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_BIN_NEXT, ST_BIN_MX, ST_BIN_MY, ST_BIN_MZ,
    ST_BIN_C1, ST_BIN_C2, ST_BIN_HRD, ST_BIN_WR,
    ST_WALK, ST_W_HEAD, ST_W_LSEC, ST_W_EMIT, ST_W_FIRST,
    ST_NB1, ST_NB2, ST_NB_RD, ST_NB_SEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   emit;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = clnp_pkg::CMD_NOP;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            clnp_pkg::MODE_LOAD: cmd = clnp_pkg::CMD_LOAD;
            clnp_pkg::MODE_BIN: begin
              cmd = clnp_pkg::CMD_BIN_INIT;
              state_nxt = ST_CLEAR;
            end
            clnp_pkg::MODE_FETCH: state_nxt = ST_WALK;
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd = clnp_pkg::CMD_CLR;
        if (stat.clr_last) state_nxt = ST_BIN_NEXT;
      end
      ST_BIN_NEXT: begin
        if (stat.bin_end) begin
          cmd = clnp_pkg::CMD_WALK_INIT;
          state_nxt = ST_IDLE;
        end else begin
          cmd = clnp_pkg::CMD_POS_RD;
          state_nxt = ST_BIN_MX;
        end
      end
      ST_BIN_MX: begin
        cmd = clnp_pkg::CMD_MUL_X;
        state_nxt = ST_BIN_MY;
      end
      ST_BIN_MY: begin
        cmd = clnp_pkg::CMD_MUL_Y;
        state_nxt = ST_BIN_MZ;
      end
      ST_BIN_MZ: begin
        cmd = clnp_pkg::CMD_MUL_Z;
        state_nxt = ST_BIN_C1;
      end
      ST_BIN_C1: begin
        cmd = clnp_pkg::CMD_CELL1;
        state_nxt = ST_BIN_C2;
      end
      ST_BIN_C2: begin
        cmd = clnp_pkg::CMD_CELL2;
        state_nxt = ST_BIN_HRD;
      end
      ST_BIN_HRD: begin
        cmd = clnp_pkg::CMD_HEAD_RD_BIN;
        state_nxt = ST_BIN_WR;
      end
      ST_BIN_WR: begin
        cmd = clnp_pkg::CMD_BIN_WR;
        state_nxt = ST_BIN_NEXT;
      end
      ST_WALK: begin
        if (stat.done) begin
          cmd = clnp_pkg::CMD_EMIT_EXH;
          emit = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.first_none) begin
          if (stat.cell_end) begin
            cmd = clnp_pkg::CMD_FINISH;
            emit = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd = clnp_pkg::CMD_HEAD_RD_CELL;
            state_nxt = ST_W_HEAD;
          end
        end else if (!stat.second_none) begin
          cmd = clnp_pkg::CMD_EMIT_PAIR;
          state_nxt = ST_W_EMIT;
        end else if (!stat.nbr_end) begin
          state_nxt = ST_NB1;
        end else begin
          cmd = clnp_pkg::CMD_LINK_RD_FIRST;
          state_nxt = ST_W_FIRST;
        end
      end
      ST_W_HEAD: begin
        cmd = clnp_pkg::CMD_FIRST_FROM_HEAD;
        state_nxt = stat.head_none ? ST_WALK : ST_W_LSEC;
      end
      ST_W_FIRST: begin
        cmd = clnp_pkg::CMD_FIRST_FROM_LINK;
        state_nxt = stat.link_none ? ST_WALK : ST_W_LSEC;
      end
      ST_W_LSEC: begin
        cmd = clnp_pkg::CMD_SEC_FROM_LINK;
        state_nxt = ST_WALK;
      end
      ST_W_EMIT: begin
        // pair is in the output register; pick up the partner's successor
        cmd = clnp_pkg::CMD_SEC_FROM_LINK;
        emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_NB1: begin
        cmd = clnp_pkg::CMD_NB1;
        state_nxt = ST_NB2;
      end
      ST_NB2: begin
        cmd = clnp_pkg::CMD_NB2;
        state_nxt = ST_NB_RD;
      end
      ST_NB_RD: begin
        cmd = clnp_pkg::CMD_NB_RD;
        state_nxt = ST_NB_SEC;
      end
      ST_NB_SEC: begin
        cmd = clnp_pkg::CMD_SEC_FROM_HEAD;
        state_nxt = ST_WALK;
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/cell_list_neighbor_pairs_unit.sv]
// Top level of the linked-cell half-shell neighbor pair generator.
// Depends on clnp_pkg, clnp_ctrl, clnp_dp (and clnp_ram through clnp_dp).
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | clnp_pkg::in_word_t (mode, index, position)
//  out_    | output    | out_valid/out_stall| clnp_pkg::out_word_t (pair or exhausted)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index (register), cfg_data
//
// Load writes one position word. Bin clears all 4096 entries of the cell head
// table, then per particle does a position read, three passes of the shared
// coordinate multiplier, two cell-index steps, a head read and a head/link write,
// then restarts the walk. Fetch returns a waiting partner's pair or the exhausted
// answer; to reach one it steps over empty cells, new first particles and neighbor
// cells, paced by the single-port head and link memory reads of the walk.
// Reset (rst_n low, synchronous) restores config defaults and an exhausted walk;
// the memories are not cleared. One word in flight at a time; a result waiting on
// out_stall holds off the next input word. Config writes are always taken.
module cell_list_neighbor_pairs_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clnp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output clnp_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  clnp_pkg::cmd_t  cmd;
  clnp_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  clnp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_mode(in_word.mode), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  clnp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_word(in_word),
    .cfg_we(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stat(stat), .out_word(out_word)
  );

endmodule

[tb/tb_cell_list_neighbor_pairs_unit.sv]
// Self-checking testbench for cell_list_neighbor_pairs_unit: loads, bins and walks pairs.
// Depends on clnp_pkg and the unit RTL; a built-in pair-walk predictor checks every word.
module tb_cell_list_neighbor_pairs_unit;
  import clnp_pkg::*;

  localparam logic [1:0]  MODE_NONE = 2'd3;      // unused mode, block ignores it
  localparam logic [10:0] NO_LINK   = 11'h7FF;   // empty head / link
  localparam int          LIMIT     = 10000000;  // cycle budget
  localparam int          HOLD_LEN  = 400;       // long receiver hold-off
  localparam int          RAND_ITEMS = 750;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  always #5 clk = ~clk;

  cell_list_neighbor_pairs_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Pair-walk predictor: own copy of registers, memories and walk state
  // ---------------------------------------------------------------------------
  logic [10:0] reg_count = 11'd1;
  logic [4:0]  reg_cx = 5'd1, reg_cy = 5'd1, reg_cz = 5'd1;
  logic [23:0] reg_ix = 24'd65536, reg_iy = 24'd65536, reg_iz = 24'd65536;
  logic        reg_2d = 1'b0;

  logic [95:0] pos_mem [MaxParticles];
  logic [10:0] cell_head [MaxCells];
  logic [10:0] chain [MaxParticles];
  bit          loaded [MaxParticles];

  int unsigned lat_cx = 1, lat_cy = 1, lat_cz = 1, lat_nn = 13, lat_ncell = 1;
  int unsigned cur_cell = 0, cur_nbr = 0;
  logic [10:0] cur_a = NO_LINK, cur_b = NO_LINK;
  bit          walk_over = 1'b1;

  // half-shell offsets, x / y / z
  int off_x [13] = '{1, 1, 0, -1, 1, 1, 0, -1, 1, 1, 0, -1, 0};
  int off_y [13] = '{0, 1, 1,  1, 0, 1, 1,  1, 0, 1, 1,  1, 0};
  int off_z [13] = '{0, 0, 0,  0, -1, -1, -1, -1, 1, 1, 1, 1, 1};

  out_word_t pair_q [$];    // expected result words, oldest first
  in_word_t  item_q [$];    // words waiting for the driver
  int        errors = 0;

  // append a word for the driver
  function automatic void enqueue(in_word_t w);
    item_q = {item_q, w};
  endfunction

  function automatic int unsigned sat_axis(logic [4:0] v);
    if (v < 5'd1) return 1;
    if (v > 5'd16) return 16;
    return v;
  endfunction

  function automatic int unsigned axis_bin(logic [31:0] p, logic [23:0] inv, int unsigned n);
    logic [55:0] prod;
    int unsigned c;
    prod = {24'd0, p} * {32'd0, inv};
    c = prod[55:32];
    if (c > n - 1) c = n - 1;
    return c;
  endfunction

  function automatic logic [10:0] head_at(int unsigned c);
    return (c < MaxCells) ? cell_head[c] : NO_LINK;
  endfunction

  function automatic logic [10:0] link_at(logic [10:0] p);
    return p[10] ? NO_LINK : chain[p[9:0]];
  endfunction

  function automatic int unsigned nbr_cell(int unsigned c, int unsigned k);
    int unsigned iz, iy, ix, nx, ny, nz;
    iz = c % lat_cz;
    iy = (c / lat_cz) % lat_cy;
    ix = c / (lat_cz * lat_cy);
    nx = (int'(ix) + off_x[k] + int'(lat_cx)) % int'(lat_cx);
    ny = (int'(iy) + off_y[k] + int'(lat_cy)) % int'(lat_cy);
    nz = (int'(iz) + off_z[k] + int'(lat_cz)) % int'(lat_cz);
    return nx * lat_cz * lat_cy + ny * lat_cz + nz;
  endfunction

  function automatic void bin_particles();
    int unsigned n, cx, cy, cz, c, prod;
    n = (reg_count > MaxParticles) ? MaxParticles : reg_count;
    lat_cx = sat_axis(reg_cx);
    lat_cy = sat_axis(reg_cy);
    lat_cz = reg_2d ? 1 : sat_axis(reg_cz);
    lat_nn = reg_2d ? 4 : 13;
    prod = lat_cx * lat_cy * lat_cz;
    lat_ncell = (prod > MaxCells) ? MaxCells : prod;
    for (int i = 0; i < MaxCells; i++) cell_head[i] = NO_LINK;
    for (int i = 0; i < MaxParticles; i++) chain[i] = NO_LINK;
    for (int i = 0; i < n; i++) begin
      cx = axis_bin(pos_mem[i][95:64], reg_ix, lat_cx);
      cy = axis_bin(pos_mem[i][63:32], reg_iy, lat_cy);
      cz = reg_2d ? 0 : axis_bin(pos_mem[i][31:0], reg_iz, lat_cz);
      c = cx * lat_cz * lat_cy + cy * lat_cz + cz;
      if (c < MaxCells) begin
        chain[i] = cell_head[c];
        cell_head[c] = 11'(i);
      end
    end
    cur_cell = 0;
    cur_a = NO_LINK;
    cur_b = NO_LINK;
    cur_nbr = 0;
    walk_over = 1'b0;
  endfunction

  // advance the walk to the next pair; 0 when exhausted
  function automatic bit next_pair(output logic [9:0] a, output logic [9:0] b);
    a = '0;
    b = '0;
    while (!walk_over) begin
      if (cur_a == NO_LINK) begin
        if (cur_cell >= lat_ncell) begin
          walk_over = 1'b1;
          break;
        end
        cur_a = head_at(cur_cell);
        if (cur_a == NO_LINK) begin
          cur_cell++;
          continue;
        end
        cur_nbr = 0;
        cur_b = link_at(cur_a);
        continue;
      end
      if (cur_b != NO_LINK) begin
        a = cur_a[9:0];
        b = cur_b[9:0];
        cur_b = link_at(cur_b);
        return 1'b1;
      end
      if (cur_nbr < lat_nn) begin
        cur_b = head_at(nbr_cell(cur_cell, cur_nbr));
        cur_nbr++;
        continue;
      end
      cur_a = link_at(cur_a);
      if (cur_a == NO_LINK) begin
        cur_cell++;
        continue;
      end
      cur_nbr = 0;
      cur_b = link_at(cur_a);
    end
    return 1'b0;
  endfunction

  function automatic void predict_word(in_word_t w);
    out_word_t r;
    logic [9:0] a, b;
    case (w.mode)
      MODE_LOAD: pos_mem[w.particle_index] = {w.pos_x, w.pos_y, w.pos_z};
      MODE_BIN: bin_particles();
      MODE_FETCH: begin
        if (next_pair(a, b)) r = '{pair_first: a, pair_second: b, status: 1'b0};
        else r = '{pair_first: 10'd0, pair_second: 10'd0, status: 1'b1};
        pair_q = {pair_q, r};
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts with random gaps, fed from item_q
  // ---------------------------------------------------------------------------
  int gap_max = 0;
  int burst_left = 0, gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_word(in_word);
        void'(item_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin   // a stalled word holds
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (item_q.size() > 0) begin
          in_valid <= 1'b1;
          in_word <= item_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int hold_asks = 0, hold_seen = 0, hold_left = 0;

  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result word with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pair_q.size() == 0) begin
        $error("unexpected result word %h", out_word);
        errors++;
      end else begin
        e = pair_q.pop_front();
        if (out_word.pair_first !== e.pair_first) begin
          $error("pair_first expected %0d got %0d", e.pair_first, out_word.pair_first);
          errors++;
        end
        if (out_word.pair_second !== e.pair_second) begin
          $error("pair_second expected %0d got %0d", e.pair_second, out_word.pair_second);
          errors++;
        end
        if (out_word.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_word.status);
          errors++;
        end
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("cell_list_neighbor_pairs_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic in_word_t mk(logic [1:0] m, logic [9:0] idx,
                                  logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_word_t w;
    w.mode = m;
    w.particle_index = idx;
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    return w;
  endfunction

  // narrow positions span cell indices 0 to 17 at unit inverse width, just past a 16-cell grid
  function automatic logic [31:0] rand_pos();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 32'h0011_0000);
  endfunction

  function automatic logic [23:0] rand_inv();
    case ($urandom_range(0, 2))
      0: return 24'd65536;
      1: return $urandom_range(0, 24'hFFFFFF);
      default: return $urandom_range(16384, 262144);
    endcase
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [23:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PARTICLE_COUNT: reg_count = d[10:0];
      REG_CELLS_X:        reg_cx = d[4:0];
      REG_CELLS_Y:        reg_cy = d[4:0];
      REG_CELLS_Z:        reg_cz = d[4:0];
      REG_INV_WIDTH_X:    reg_ix = d;
      REG_INV_WIDTH_Y:    reg_iy = d;
      REG_INV_WIDTH_Z:    reg_iz = d;
      REG_TWO_DIM:        reg_2d = d[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    wait (item_q.size() == 0 && pair_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic push_load(input logic [9:0] idx);
    enqueue(mk(MODE_LOAD, idx, rand_pos(), rand_pos(), rand_pos()));
    loaded[idx] = 1'b1;
  endtask

  initial begin
    int rand_items;
    int eff, fetches, phase;
    logic [23:0] cnt;

    for (int i = 0; i < MaxCells; i++) cell_head[i] = NO_LINK;
    for (int i = 0; i < MaxParticles; i++) begin
      chain[i] = NO_LINK;
      loaded[i] = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fetch before any bin, unused mode, index / position extremes,
    // then a lone particle in a single cell pairs with itself via every wrap
    enqueue(mk(MODE_FETCH, '0, '0, '0, '0));
    enqueue(mk(MODE_NONE, 10'h3FF, '1, '1, '1));
    enqueue(mk(MODE_LOAD, 10'd0, '1, '1, '1));
    enqueue(mk(MODE_LOAD, 10'h3FF, '0, '0, '0));
    loaded[0] = 1'b1;
    loaded[1023] = 1'b1;
    enqueue(mk(MODE_BIN, '0, '0, '0, '0));
    repeat (16) enqueue(mk(MODE_FETCH, '0, '0, '0, '0));
    wait_idle();

    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();   // every phase ends on a fetch, so idle here means truly idle
      stall_pct = (phase % 4 == 0) ? 0 : $urandom_range(0, 60);
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);

      // registers: extremes on the first phases, random after
      case (phase)
        0: begin
          cnt = 24;
          write_reg(REG_CELLS_X, 24'd16); write_reg(REG_CELLS_Y, 24'd16);
          write_reg(REG_CELLS_Z, 24'd16);
          write_reg(REG_INV_WIDTH_X, 24'hFFFFFF); write_reg(REG_INV_WIDTH_Y, 24'hFFFFFF);
          write_reg(REG_INV_WIDTH_Z, 24'hFFFFFF); write_reg(REG_TWO_DIM, 24'd0);
        end
        1: begin
          cnt = 0;
          write_reg(REG_CELLS_X, 24'd0); write_reg(REG_CELLS_Y, 24'd31);
          write_reg(REG_CELLS_Z, 24'd0);
          write_reg(REG_INV_WIDTH_X, 24'd0); write_reg(REG_INV_WIDTH_Y, 24'd0);
          write_reg(REG_INV_WIDTH_Z, 24'd0); write_reg(REG_TWO_DIM, 24'd1);
        end
        default: begin
          if (phase == 2) cnt = 24'h0008C8;     // bit 11 drops, leaving 200 particles
          else if ($urandom_range(0, 9) == 0) cnt = 0;
          else cnt = $urandom_range(1, 24);
          write_reg(REG_CELLS_X, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(1, 5));
          write_reg(REG_CELLS_Y, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(1, 5));
          write_reg(REG_CELLS_Z, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                             : $urandom_range(1, 5));
          write_reg(REG_INV_WIDTH_X, rand_inv());
          write_reg(REG_INV_WIDTH_Y, rand_inv());
          write_reg(REG_INV_WIDTH_Z, rand_inv());
          write_reg(REG_TWO_DIM, $urandom_range(0, 1));
        end
      endcase
      write_reg(REG_PARTICLE_COUNT, cnt);
      eff = (cnt[10:0] > MaxParticles) ? MaxParticles : cnt[10:0];

      // every binned particle must hold a loaded position
      for (int i = 0; i < eff; i++)
        if (!loaded[i] || $urandom_range(0, 1)) begin
          push_load(i);
          rand_items++;
        end
      enqueue(mk(MODE_BIN, $urandom, $urandom, $urandom, $urandom));
      rand_items++;

      // tiny sets are walked to exhaustion, larger ones partly
      fetches = (eff <= 4) ? 14 * eff * eff + 2 : $urandom_range(1, 60);
      for (int f = 0; f < fetches; f++) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: enqueue(mk(MODE_NONE, $urandom, $urandom, $urandom, $urandom));
            1: begin push_load($urandom_range(0, MaxParticles - 1)); rand_items++; end
            default: begin
              enqueue(mk(MODE_BIN, '0, '0, '0, '0));
              rand_items++;
            end
          endcase
        end
        enqueue(mk(MODE_FETCH, $urandom, $urandom, $urandom, $urandom));
        rand_items++;
      end

      // fill the block while the receiver holds off
      if (phase == 3 || phase == 9) hold_asks++;
      phase++;
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0 && pair_q.size() == 0) begin
      $display("cell_list_neighbor_pairs_unit test passed");
    end else begin
      $display("cell_list_neighbor_pairs_unit test failed");
    end
    $finish;
  end

endmodule
